// File: src/dual_marker_rle_decoder_assert.svh
// Assertion macros for the dual marker run-length decoder.
`ifndef DUAL_MARKER_RLE_DECODER_ASSERT_SVH
`define DUAL_MARKER_RLE_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checks that the consequent holds in the same cycle as the antecedent.
`define DMRD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define DMRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DMRD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define DMRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/dmrd_pkg.sv
// Shared types and constants of the dual marker run-length decoder.
package dmrd_pkg;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 16;
  localparam int SIZE_W  = 24;
  localparam int TOTAL_W = 25;
  localparam int ADDR_W  = 2;

  localparam logic [ADDR_W-1:0] REG_SHORT_MARKER = 2'd0;
  localparam logic [ADDR_W-1:0] REG_LONG_MARKER  = 2'd1;
  localparam logic [ADDR_W-1:0] REG_IMAGE_SIZE   = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0]  value;
    logic [LEN_W-1:0]   length;
    logic [TOTAL_W-1:0] total;
  } run_token_t;

  typedef struct packed {
    logic [BYTE_W-1:0] short_marker;
    logic [BYTE_W-1:0] long_marker;
    logic [SIZE_W-1:0] image_size;
  } cfg_regs_t;

  typedef struct packed {
    logic finished;
    logic push;
  } front_status_t;

endpackage

// File: src/dmrd_ifs.sv
// Valid/ready channel interfaces for input bytes, run words and configuration writes.
interface dmrd_in_if import dmrd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface dmrd_out_if import dmrd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] run_value;
  logic [LEN_W-1:0]  run_length;
  logic              image_done;

  modport source (output valid, output run_value, output run_length, output image_done,
                  input ready);
  modport sink (input valid, input run_value, input run_length, input image_done,
                output ready);
endinterface

interface dmrd_cfg_if import dmrd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] addr;
  logic [SIZE_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

// File: src/dual_marker_rle_decoder.sv
// Top level of the dual marker run-length decoder with configuration registers.
//
// Compressed bytes enter on in_chan, one word per accepted handshake. A byte equal to
// the short marker opens a token of marker, value and 8-bit count; failing that, a byte
// equal to the long marker opens a token with a big-endian 16-bit count. Any other byte
// is a run of length one. Each finished token with a nonzero count leaves on out_chan
// as one word of value, length and the image_done flag. Once the running total has
// reached the image size at a token start, all later bytes are taken and dropped.
// Configuration writes on cfg_chan are always taken; the user must make them only while
// the block is idle, and the block itself does not enforce this.
// Throughput is one byte per cycle while the token queue is not full: the parser decides
// each byte combinationally and a run word leaves every cycle the receiver takes one.
// A byte that completes a token is pushed into the token queue and then loaded into the
// output register that drives out_chan. When the receiver stalls, words wait in the output
// register and the queue; in_chan.ready drops only when the queue is full.
// Reset clears the registers, the parser, the total, the token queue and out_chan's valid state.
module dual_marker_rle_decoder import dmrd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  dmrd_in_if.sink     in_chan,
  dmrd_out_if.source  out_chan,
  dmrd_cfg_if.sink    cfg_chan
);

`include "dual_marker_rle_decoder_assert.svh"

  cfg_regs_t     cfg_r, cfg_nxt;
  logic          q_full;
  logic          q_empty;
  logic          push;
  logic          pop;
  run_token_t    push_token;
  run_token_t    pop_token;
  front_status_t front_status;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.addr)
        REG_SHORT_MARKER: cfg_nxt.short_marker = cfg_chan.data[BYTE_W-1:0];
        REG_LONG_MARKER:  cfg_nxt.long_marker  = cfg_chan.data[BYTE_W-1:0];
        REG_IMAGE_SIZE:   cfg_nxt.image_size   = cfg_chan.data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dmrd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg        (cfg_r),
    .q_full     (q_full),
    .push       (push),
    .push_token (push_token),
    .status     (front_status)
  );

  dmrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_token (push_token),
    .pop        (pop),
    .pop_token  (pop_token),
    .full       (q_full),
    .empty      (q_empty)
  );

  dmrd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_token  (pop_token),
    .pop      (pop),
    .out_chan (out_chan)
  );

  `DMRD_ASSERT_SAME(a_no_run_after_finish, clk, rst_n, front_status.finished,
    !front_status.push, "A run was produced after the image was finished.")
  `DMRD_ASSERT_NEXT(a_finish_sticky, clk, rst_n, front_status.finished,
    front_status.finished, "The finished flag cleared without a reset.")
  `DMRD_ASSERT_SAME(a_nonzero_length, clk, rst_n, out_chan.valid,
    out_chan.run_length != '0, "A run word with zero length was presented.")

endmodule

// File: src/dmrd_front.sv
// Token parser that turns accepted bytes into run tokens and keeps the output total.
module dmrd_front import dmrd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  dmrd_in_if.sink       in_chan,
  input  cfg_regs_t     cfg,
  input  logic          q_full,
  output logic          push,
  output run_token_t    push_token,
  output front_status_t status
);

  localparam logic [1:0] PH_START    = 2'd0;
  localparam logic [1:0] PH_VALUE    = 2'd1;
  localparam logic [1:0] PH_COUNT    = 2'd2;
  localparam logic [1:0] PH_COUNT_LO = 2'd3;

  logic [1:0]         phase_r, phase_nxt;
  logic               is_long_r, is_long_nxt;
  logic [BYTE_W-1:0]  held_r, held_nxt;
  logic [BYTE_W-1:0]  high_r, high_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               finished_r, finished_nxt;
  logic               accept;
  logic [BYTE_W-1:0]  b;
  logic [BYTE_W-1:0]  tok_value;
  logic [LEN_W-1:0]   tok_len;
  logic               tok_emit;
  logic [TOTAL_W-1:0] total_after;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign b             = in_chan.in_byte;
  assign total_after   = total_r + TOTAL_W'(tok_len);

  always_comb begin
    phase_nxt    = phase_r;
    is_long_nxt  = is_long_r;
    held_nxt     = held_r;
    high_nxt     = high_r;
    finished_nxt = finished_r;
    tok_value    = b;
    tok_len      = LEN_W'(1);
    tok_emit     = 1'b0;
    if (accept && !finished_r) begin
      unique case (phase_r)
        PH_START: begin
          if (total_r >= {1'b0, cfg.image_size}) begin
            finished_nxt = 1'b1;
          end else if (b == cfg.short_marker) begin
            is_long_nxt = 1'b0;
            phase_nxt   = PH_VALUE;
          end else if (b == cfg.long_marker) begin
            is_long_nxt = 1'b1;
            phase_nxt   = PH_VALUE;
          end else begin
            tok_emit = 1'b1;
          end
        end
        PH_VALUE: begin
          held_nxt  = b;
          phase_nxt = PH_COUNT;
        end
        PH_COUNT: begin
          if (is_long_r) begin
            high_nxt  = b;
            phase_nxt = PH_COUNT_LO;
          end else begin
            phase_nxt = PH_START;
            tok_value = held_r;
            tok_len   = {{(LEN_W-BYTE_W){1'b0}}, b};
            tok_emit  = (b != '0);
          end
        end
        PH_COUNT_LO: begin
          phase_nxt = PH_START;
          tok_value = held_r;
          tok_len   = {high_r, b};
          tok_emit  = ({high_r, b} != '0);
        end
        default: begin
          phase_nxt = PH_START;
        end
      endcase
    end
    total_nxt = tok_emit ? total_after : total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      is_long_r  <= 1'b0;
      held_r     <= '0;
      high_r     <= '0;
      total_r    <= '0;
      finished_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      is_long_r  <= is_long_nxt;
      held_r     <= held_nxt;
      high_r     <= high_nxt;
      total_r    <= total_nxt;
      finished_r <= finished_nxt;
    end
  end

  assign push              = tok_emit;
  assign push_token.value  = tok_value;
  assign push_token.length = tok_len;
  assign push_token.total  = total_after;
  assign status.finished   = finished_r;
  assign status.push       = tok_emit;

endmodule

// File: src/dmrd_queue.sv
// Small register queue of run tokens between the parser and the output stage.
module dmrd_queue import dmrd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  run_token_t push_token,
  input  logic       pop,
  output run_token_t pop_token,
  output logic       full,
  output logic       empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_token_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_token;
    end
  end

  assign pop_token = mem_r[rd_ptr_r];

endmodule

// File: src/dmrd_back.sv
// Output stage that judges image completion and holds each run word for the receiver.
module dmrd_back import dmrd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_regs_t  cfg,
  input  logic       q_empty,
  input  run_token_t q_token,
  output logic       pop,
  dmrd_out_if.source out_chan
);

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] value_r;
  logic [LEN_W-1:0]  length_r;
  logic              done_r;
  logic              load;

  assign load = !q_empty && (!valid_r || out_chan.ready);
  assign pop  = load;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r  <= q_token.value;
      length_r <= q_token.length;
      done_r   <= (q_token.total >= {1'b0, cfg.image_size});
    end
  end

  assign out_chan.valid      = valid_r;
  assign out_chan.run_value  = value_r;
  assign out_chan.run_length = length_r;
  assign out_chan.image_done = done_r;

endmodule
